FILE: hdl/ced_pkg.sv
// ced_pkg: shared types, constants and vector table for the exception dispatch block
// no dependencies
package ced_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned EXC_COUNT = 8;
    localparam int unsigned CODE_W    = 3;

    localparam logic [XLEN-1:0] SAVE_MASK  = 32'h87C0_FFFF;
    localparam logic [XLEN-1:0] CLEAR_MASK = 32'h0004_EF36;
    localparam logic [XLEN-1:0] TRAP_BIT   = 32'h0004_0000;
    localparam logic [XLEN-1:0] EE_BIT     = 32'h0000_8000;

    localparam int unsigned ILE_POS = 16;

    localparam logic [CODE_W-1:0] EXC_ISI   = 3'd0;
    localparam logic [CODE_W-1:0] EXC_PROG  = 3'd1;
    localparam logic [CODE_W-1:0] EXC_SC    = 3'd2;
    localparam logic [CODE_W-1:0] EXC_FPU   = 3'd3;
    localparam logic [CODE_W-1:0] EXC_DSI   = 3'd4;
    localparam logic [CODE_W-1:0] EXC_ALIGN = 3'd5;
    localparam logic [CODE_W-1:0] EXC_EXT   = 3'd6;
    localparam logic [CODE_W-1:0] EXC_DEC   = 3'd7;

    typedef struct packed {
        logic              taken;
        logic [CODE_W-1:0] code;
    } exc_sel_t;

    function automatic logic [XLEN-1:0] exc_vector(input logic [CODE_W-1:0] code);
        logic [XLEN-1:0] vec;
        unique case (code)
            EXC_ISI:   vec = 32'h8000_0400;
            EXC_PROG:  vec = 32'h8000_0700;
            EXC_SC:    vec = 32'h8000_0C00;
            EXC_FPU:   vec = 32'h8000_0800;
            EXC_DSI:   vec = 32'h8000_0300;
            EXC_ALIGN: vec = 32'h8000_0600;
            EXC_EXT:   vec = 32'h8000_0500;
            EXC_DEC:   vec = 32'h8000_0900;
            default:   vec = 32'h8000_0400;
        endcase
        return vec;
    endfunction

    // srr0 takes the next pc for these, the current pc otherwise
    function automatic logic exc_saves_next(input logic [CODE_W-1:0] code);
        logic use_next;
        case (code) inside
            EXC_ISI, EXC_SC, EXC_EXT, EXC_DEC: use_next = 1'b1;
            default:                           use_next = 1'b0;
        endcase
        return use_next;
    endfunction

endpackage

FILE: hdl/ced_sel.sv
// ced_sel: merges raised bits into the pending mask and picks the exception by priority
// depends on ced_pkg
module ced_sel (
    input  logic [ced_pkg::EXC_COUNT-1:0] pending,
    input  logic [ced_pkg::EXC_COUNT-1:0] raise_mask,
    input  logic                          ee,
    output ced_pkg::exc_sel_t             sel,
    output logic [ced_pkg::EXC_COUNT-1:0] pending_next
);
    import ced_pkg::*;

    logic [EXC_COUNT-1:0] merged;

    always_comb
    begin
        merged    = pending | raise_mask;
        sel.taken = 1'b0;
        sel.code  = '0;
        // scan downward so the lowest set bit wins
        if (ee && merged[EXC_DEC])
        begin
            sel.taken = 1'b1;
            sel.code  = EXC_DEC;
        end
        if (ee && merged[EXC_EXT])
        begin
            sel.taken = 1'b1;
            sel.code  = EXC_EXT;
        end
        for (int i = int'(EXC_ALIGN); i >= 0; i--)
        begin
            if (merged[i[CODE_W-1:0]])
            begin
                sel.taken = 1'b1;
                sel.code  = CODE_W'(i);
            end
        end
        pending_next = merged;
        if (sel.taken)
        begin
            pending_next[sel.code] = 1'b0;
        end
    end

endmodule

FILE: hdl/ced_entry.sv
// ced_entry: builds the new srr0, srr1, msr and next pc for the selected exception
// depends on ced_pkg
module ced_entry (
    input  ced_pkg::exc_sel_t          sel,
    input  logic [ced_pkg::XLEN-1:0]   cur_pc,
    input  logic [ced_pkg::XLEN-1:0]   next_pc,
    input  logic [ced_pkg::XLEN-1:0]   msr_in,
    input  logic [ced_pkg::XLEN-1:0]   srr0_in,
    input  logic [ced_pkg::XLEN-1:0]   srr1_in,
    output logic [ced_pkg::XLEN-1:0]   npc_new,
    output logic [ced_pkg::XLEN-1:0]   srr0_new,
    output logic [ced_pkg::XLEN-1:0]   srr1_new,
    output logic [ced_pkg::XLEN-1:0]   msr_new
);
    import ced_pkg::*;

    logic [XLEN-1:0] saved;

    always_comb
    begin
        saved    = msr_in & SAVE_MASK;
        npc_new  = next_pc;
        srr0_new = srr0_in;
        srr1_new = srr1_in;
        msr_new  = msr_in;
        if (sel.taken)
        begin
            npc_new  = exc_vector(sel.code);
            srr0_new = exc_saves_next(sel.code) ? next_pc : cur_pc;
            if (sel.code == EXC_ISI)
            begin
                srr1_new = srr1_in | saved;
            end
            else if (sel.code == EXC_PROG)
            begin
                srr1_new = saved | TRAP_BIT;
            end
            else
            begin
                srr1_new = saved;
            end
            // ile ORed into le, then the entry bits cleared
            msr_new = (msr_in | {{(XLEN-1){1'b0}}, msr_in[ILE_POS]}) & ~CLEAR_MASK;
        end
    end

endmodule

FILE: hdl/cpu_exception_dispatch.sv
// Exception entry check, one transaction per instruction boundary. A check is accepted in
// every cycle in which the result register is empty or being read. The result is registered
// on acceptance, and a new check may enter in the same cycle the previous result is taken,
// so throughput is one check per cycle while out_ready holds. The pending mask is updated on
// acceptance, so back-to-back checks see each other's pending bits. Reset clears the pending mask.
// depends on ced_pkg, ced_sel, ced_entry
module cpu_exception_dispatch (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ced_pkg::XLEN-1:0]       cur_pc,
    input  logic [ced_pkg::XLEN-1:0]       next_pc,
    input  logic [ced_pkg::XLEN-1:0]       msr_in,
    input  logic [ced_pkg::XLEN-1:0]       srr0_in,
    input  logic [ced_pkg::XLEN-1:0]       srr1_in,
    input  logic [ced_pkg::EXC_COUNT-1:0]  raise_mask,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           taken,
    output logic [ced_pkg::CODE_W-1:0]     exc_code,
    output logic [ced_pkg::XLEN-1:0]       npc_out,
    output logic [ced_pkg::XLEN-1:0]       srr0_out,
    output logic [ced_pkg::XLEN-1:0]       srr1_out,
    output logic [ced_pkg::XLEN-1:0]       msr_out,
    output logic [ced_pkg::EXC_COUNT-1:0]  pending_out
);
    import ced_pkg::*;

    logic [EXC_COUNT-1:0] pending_reg;
    logic [EXC_COUNT-1:0] pending_next;
    logic                 valid_reg;
    exc_sel_t             sel;
    logic                 accept;

    logic [XLEN-1:0] npc_next;
    logic [XLEN-1:0] srr0_next;
    logic [XLEN-1:0] srr1_next;
    logic [XLEN-1:0] msr_next;

    logic                 taken_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [XLEN-1:0]      npc_reg;
    logic [XLEN-1:0]      srr0_reg;
    logic [XLEN-1:0]      srr1_reg;
    logic [XLEN-1:0]      msr_reg;
    logic [EXC_COUNT-1:0] pend_out_reg;

    assign in_ready = out_ready || !valid_reg;
    assign accept   = in_valid && in_ready;

    ced_sel u_sel (
        .pending      (pending_reg),
        .raise_mask   (raise_mask),
        .ee           ((msr_in & EE_BIT) != '0),
        .sel          (sel),
        .pending_next (pending_next)
    );

    ced_entry u_entry (
        .sel      (sel),
        .cur_pc   (cur_pc),
        .next_pc  (next_pc),
        .msr_in   (msr_in),
        .srr0_in  (srr0_in),
        .srr1_in  (srr1_in),
        .npc_new  (npc_next),
        .srr0_new (srr0_next),
        .srr1_new (srr1_next),
        .msr_new  (msr_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pending_reg <= pending_next;
                valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            taken_reg    <= sel.taken;
            code_reg     <= sel.code;
            npc_reg      <= npc_next;
            srr0_reg     <= srr0_next;
            srr1_reg     <= srr1_next;
            msr_reg      <= msr_next;
            pend_out_reg <= pending_next;
        end
    end

    assign out_valid   = valid_reg;
    assign taken       = taken_reg;
    assign exc_code    = code_reg;
    assign npc_out     = npc_reg;
    assign srr0_out    = srr0_reg;
    assign srr1_out    = srr1_reg;
    assign msr_out     = msr_reg;
    assign pending_out = pend_out_reg;

endmodule
